>>> hdl/cfd_pkg.sv
// cfd_pkg: shared types, register codes and reset values for the crossfade dither block
// no dependencies; used by every file in hdl/

package cfd_pkg;

	localparam int MAX_FIELDS_DEF     = 512;
	localparam int MAX_FIELD_SIZE_DEF = 8;
	localparam int QUEUE_DEPTH        = 4;
	localparam int PIPE_SLOTS         = 4;
	localparam int CFG_IDX_W          = 3;
	localparam int CFG_DATA_W         = 24;
	localparam int SUB_W              = 3;
	localparam int INDEX_W            = 12;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GAIN      = 3'd0,
		REG_BLACK     = 3'd1,
		REG_NO_DITHER = 3'd2,
		REG_FSIZE     = 3'd3,
		REG_FCOUNT    = 3'd4,
		REG_CMAP      = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic [7:0]  gain_code;
		logic [7:0]  black_point;
		logic [7:0]  no_dither_point;
		logic [3:0]  field_size;
		logic [9:0]  field_count;
		logic [23:0] channel_map;
	} cfg_t;

	localparam logic [7:0]  GAIN_RST   = 8'd255;
	localparam logic [7:0]  BLACK_RST  = 8'd0;
	localparam logic [7:0]  NODITH_RST = 8'd0;
	localparam logic [3:0]  FSIZE_RST  = 4'd3;
	localparam logic [9:0]  FCOUNT_RST = 10'd512;
	localparam logic [23:0] CMAP_RST   = 24'hFAC688;

	typedef struct packed {
		logic [7:0]         origin_value;
		logic [7:0]         target_value;
		logic [7:0]         progress_code;
		logic [INDEX_W-1:0] byte_index;
		logic               frame_done;
	} item_t;

	typedef struct packed {
		logic valid;
		logic full;
	} q_status_t;

endpackage

>>> hdl/cfd_if.sv
// cfd_if: valid/ready channel interfaces for item input, result output and register writes
// depends on cfd_pkg

interface cfd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] origin_value;
	logic [7:0] target_value;
	logic [7:0] progress_code;

	modport source (output valid, origin_value, target_value, progress_code, input ready);
	modport sink (input valid, origin_value, target_value, progress_code, output ready);
endinterface

interface cfd_out_if;
	logic                        valid;
	logic                        ready;
	logic [cfd_pkg::INDEX_W-1:0] byte_index;
	logic [7:0]                  out_value;
	logic                        frame_done;

	modport source (output valid, byte_index, out_value, frame_done, input ready);
	modport sink (input valid, byte_index, out_value, frame_done, output ready);
endinterface

interface cfd_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [cfd_pkg::CFG_IDX_W-1:0]  index;
	logic [cfd_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

>>> hdl/cfd_front.sv
// cfd_front: accepts input transfers, walks field/subfield counters, forms store position
// and byte index; depends on cfd_pkg and cfd_if

module cfd_front #(
	parameter int MAX_FIELDS     = cfd_pkg::MAX_FIELDS_DEF,
	parameter int MAX_FIELD_SIZE = cfd_pkg::MAX_FIELD_SIZE_DEF,
	localparam int DEPTH         = MAX_FIELDS * MAX_FIELD_SIZE,
	localparam int PW            = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cfd_pkg::cfg_t        cfg,
	input  logic                 accept_ok,
	cfd_in_if.sink               feed,
	output logic                 push,
	output cfd_pkg::item_t       item,
	output logic [PW-1:0]        pos
);

	localparam int FW  = (MAX_FIELDS > 1) ? $clog2(MAX_FIELDS) : 1;
	localparam int CW  = ($clog2(MAX_FIELDS + 1) > 10) ? $clog2(MAX_FIELDS + 1) : 10;
	localparam int IW  = FW + 5;
	localparam int SW  = cfd_pkg::SUB_W;

	logic [SW-1:0] sub_q;
	logic [FW-1:0] fld_q;
	logic [3:0]    size;
	logic [CW-1:0] fc;
	logic [CW-1:0] cnt;
	logic [SW-1:0] sub;
	logic [FW-1:0] fld;
	logic          sub_end;
	logic          fld_end;
	logic [SW-1:0] dest;
	logic [IW-1:0] lin_base;

	assign feed.ready = accept_ok;
	assign push       = feed.valid && accept_ok;

	always_comb begin
		fc = CW'(cfg.field_count);
		if (cfg.field_size == 4'd0) begin
			size = 4'd1;
		end else if (cfg.field_size > 4'(MAX_FIELD_SIZE)) begin
			size = 4'(MAX_FIELD_SIZE);
		end else begin
			size = cfg.field_size;
		end
		if (fc == '0) begin
			cnt = CW'(1);
		end else if (fc > CW'(MAX_FIELDS)) begin
			cnt = CW'(MAX_FIELDS);
		end else begin
			cnt = fc;
		end
		// hold counters inside the current limits
		sub      = (4'(sub_q) >= size) ? SW'(size - 4'd1) : sub_q;
		fld      = (CW'(fld_q) >= cnt) ? FW'(cnt - CW'(1)) : fld_q;
		sub_end  = (4'(sub) + 4'd1) >= size;
		fld_end  = (CW'(fld) + CW'(1)) >= cnt;
		dest     = cfg.channel_map[SW*sub +: SW];
		lin_base = IW'(fld) * IW'(size);
		pos      = PW'(lin_base + IW'(sub));

		item.origin_value  = feed.origin_value;
		item.target_value  = feed.target_value;
		item.progress_code = feed.progress_code;
		item.byte_index    = cfd_pkg::INDEX_W'(lin_base + IW'(dest));
		item.frame_done    = sub_end && fld_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sub_q <= '0;
			fld_q <= '0;
		end else if (push) begin
			if (sub_end) begin
				sub_q <= '0;
				fld_q <= fld_end ? '0 : fld + FW'(1);
			end else begin
				sub_q <= sub + SW'(1);
			end
		end
	end

endmodule

>>> hdl/cfd_queue.sv
// cfd_queue: short fifo decoupling the front end from the back end
// depends on cfd_pkg

module cfd_queue #(
	parameter int WIDTH = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  logic [WIDTH-1:0]   din,
	input  logic               pop,
	output logic [WIDTH-1:0]   dout,
	output cfd_pkg::q_status_t status
);

	localparam int D  = cfd_pkg::QUEUE_DEPTH;
	localparam int AW = (D > 1) ? $clog2(D) : 1;
	localparam int NW = $clog2(D + 1);

	logic [WIDTH-1:0] slot_q [D];
	logic [AW-1:0]    wr_q;
	logic [AW-1:0]    rd_q;
	logic [NW-1:0]    fill_q;

	assign dout         = slot_q[rd_q];
	assign status.valid = fill_q != '0;
	assign status.full  = fill_q == NW'(D);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= '0;
			rd_q   <= '0;
			fill_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == AW'(D - 1)) ? '0 : wr_q + AW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == AW'(D - 1)) ? '0 : rd_q + AW'(1);
			end
			case ({push, pop})
				2'b10:   fill_q <= fill_q + NW'(1);
				2'b01:   fill_q <= fill_q - NW'(1);
				default: fill_q <= fill_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= din;
		end
	end

endmodule

>>> hdl/cfd_back.sv
// cfd_back: blend, gain scale and residual dither pipeline with the residual store,
// its clearing pass and the output register; depends on cfd_pkg and cfd_if

module cfd_back #(
	parameter int MAX_FIELDS     = cfd_pkg::MAX_FIELDS_DEF,
	parameter int MAX_FIELD_SIZE = cfd_pkg::MAX_FIELD_SIZE_DEF,
	localparam int DEPTH         = MAX_FIELDS * MAX_FIELD_SIZE,
	localparam int PW            = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic           clk,
	input  logic           arst_n,
	input  cfd_pkg::cfg_t  cfg,
	input  logic           q_valid,
	input  cfd_pkg::item_t q_item,
	input  logic [PW-1:0]  q_pos,
	output logic           pop,
	output logic           clearing,
	cfd_out_if.source      result
);

	localparam int IXW = cfd_pkg::INDEX_W;

	logic [7:0] mem [DEPTH];

	logic           clr_q;
	logic [PW-1:0]  clr_addr_q;
	logic           adv;

	logic           v_s1;
	cfd_pkg::item_t item_s1;
	logic [PW-1:0]  pos_s1;

	logic           v_s2;
	logic [15:0]    blend_s2;
	logic [PW-1:0]  pos_s2;
	logic [IXW-1:0] idx_s2;
	logic           last_s2;

	logic           v_s3;
	logic [23:0]    mix_s3;
	logic [PW-1:0]  pos_s3;
	logic [IXW-1:0] idx_s3;
	logic           last_s3;
	logic [7:0]     rd_q;
	logic [7:0]     byp_q;
	logic           byp_hit_q;

	logic           out_valid_q;
	logic [IXW-1:0] idx_q;
	logic [7:0]     val_q;
	logic           done_q;

	logic [8:0]     ow;
	logic [8:0]     tw;
	logic [16:0]    blend_w;
	logic [8:0]     scale;
	logic [24:0]    mix_w;
	logic           blackout;
	logic [7:0]     res;
	logic [9:0]     err;
	logic [7:0]     mix8;
	logic [9:0]     carry_sum;
	logic [7:0]     dith;
	logic [7:0]     rval;
	logic [7:0]     wval;

	assign clearing = clr_q;
	assign adv      = !out_valid_q || result.ready;
	assign pop      = adv && q_valid && !clr_q;

	assign result.valid      = out_valid_q;
	assign result.byte_index = idx_q;
	assign result.out_value  = val_q;
	assign result.frame_done = done_q;

	// stage 1: weighted blend of the two bytes
	always_comb begin
		ow      = 9'd256 - 9'(item_s1.progress_code);
		tw      = 9'(item_s1.progress_code) + 9'd1;
		blend_w = 17'(item_s1.origin_value) * 17'(ow) + 17'(item_s1.target_value) * 17'(tw);
	end

	// stage 2: gain scale
	always_comb begin
		scale = 9'(cfg.gain_code) + 9'd1;
		mix_w = 25'(scale) * 25'(blend_s2);
	end

	// stage 3: residual carry, clamp and black clip
	always_comb begin
		blackout  = scale <= 9'(cfg.black_point);
		res       = byp_hit_q ? byp_q : rd_q;
		mix8      = mix_s3[23:16];
		err       = 10'(res) + 10'(mix_s3[15:8]) + 10'(mix_s3[7:0]);
		carry_sum = 10'(mix8) + 10'(err[9:8]);
		if (mix8 >= cfg.no_dither_point) begin
			dith = (carry_sum > 10'd255) ? 8'd255 : carry_sum[7:0];
		end else begin
			dith = mix8;
		end
		if (blackout) begin
			rval = 8'd0;
			wval = 8'd0;
		end else begin
			rval = (dith <= cfg.black_point) ? 8'd0 : dith;
			wval = err[7:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= 1'b1;
			clr_addr_q  <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (clr_q) begin
				if (clr_addr_q == PW'(DEPTH - 1)) begin
					clr_q <= 1'b0;
				end else begin
					clr_addr_q <= clr_addr_q + PW'(1);
				end
			end
			if (adv) begin
				v_s1        <= pop;
				v_s2        <= v_s1;
				v_s3        <= v_s2;
				out_valid_q <= v_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_s1   <= q_item;
			pos_s1    <= q_pos;
			blend_s2  <= blend_w[15:0];
			pos_s2    <= pos_s1;
			idx_s2    <= item_s1.byte_index;
			last_s2   <= item_s1.frame_done;
			mix_s3    <= mix_w[23:0];
			pos_s3    <= pos_s2;
			idx_s3    <= idx_s2;
			last_s3   <= last_s2;
			// write from stage 3 lands on this same edge
			byp_hit_q <= v_s3 && (pos_s3 == pos_s2);
			byp_q     <= wval;
			idx_q     <= idx_s3;
			val_q     <= rval;
			done_q    <= last_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (clr_q) begin
			mem[clr_addr_q] <= 8'd0;
		end else if (adv && v_s3) begin
			mem[pos_s3] <= wval;
		end
		if (adv) begin
			rd_q <= mem[pos_s2];
		end
	end

endmodule

>>> hdl/crossfade_temporal_dither_top.sv
// crossfade_temporal_dither_top: configuration registers, front end, queue and back end
// depends on cfd_pkg, cfd_if, cfd_front, cfd_queue, cfd_back
//
// usage
//   feed carries origin byte, target byte and progress code; one transfer per item.
//   result carries byte index, output byte and frame-done flag; one transfer per item.
//   cfg writes register index 0..5 (gain, black point, no-dither point, field size,
//   field count, channel map); ready is always high, write only while idle.
//   path: each item passes the queue, stages 1 to 3 and the output register.
//   throughput: one item per cycle while the receiver is ready; the residual store takes one read and one write
//   per cycle, with a bypass for back-to-back items at the same position.
//   reset: registers take their defaults, counters go to zero, and a clearing pass
//   writes zero to all MAX_FIELDS*MAX_FIELD_SIZE residual entries, one per cycle, and
//   feed.ready stays low meanwhile.
//   receiver stall: the pipeline holds, the 4-entry queue keeps taking items until
//   full, then feed.ready drops.

module crossfade_temporal_dither_top #(
	parameter int MAX_FIELDS     = cfd_pkg::MAX_FIELDS_DEF,
	parameter int MAX_FIELD_SIZE = cfd_pkg::MAX_FIELD_SIZE_DEF
) (
	input logic clk,
	input logic arst_n,
	cfd_in_if.sink    feed,
	cfd_out_if.source result,
	cfd_cfg_if.sink   cfg
);

	localparam int DEPTH = MAX_FIELDS * MAX_FIELD_SIZE;
	localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int QW    = $bits(cfd_pkg::item_t) + PW;

	cfd_pkg::cfg_t      cfg_q;
	cfd_pkg::q_status_t q_status;
	cfd_pkg::item_t     f_item;
	cfd_pkg::item_t     q_item;
	logic [PW-1:0]      f_pos;
	logic [PW-1:0]      q_pos;
	logic               push;
	logic               pop;
	logic               clearing;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_code       <= cfd_pkg::GAIN_RST;
			cfg_q.black_point     <= cfd_pkg::BLACK_RST;
			cfg_q.no_dither_point <= cfd_pkg::NODITH_RST;
			cfg_q.field_size      <= cfd_pkg::FSIZE_RST;
			cfg_q.field_count     <= cfd_pkg::FCOUNT_RST;
			cfg_q.channel_map     <= cfd_pkg::CMAP_RST;
		end else if (cfg.valid) begin
			case (cfd_pkg::cfg_reg_t'(cfg.index))
				cfd_pkg::REG_GAIN:      cfg_q.gain_code       <= cfg.data[7:0];
				cfd_pkg::REG_BLACK:     cfg_q.black_point     <= cfg.data[7:0];
				cfd_pkg::REG_NO_DITHER: cfg_q.no_dither_point <= cfg.data[7:0];
				cfd_pkg::REG_FSIZE:     cfg_q.field_size      <= cfg.data[3:0];
				cfd_pkg::REG_FCOUNT:    cfg_q.field_count     <= cfg.data[9:0];
				cfd_pkg::REG_CMAP:      cfg_q.channel_map     <= cfg.data[23:0];
				default: ;
			endcase
		end
	end

	cfd_front #(
		.MAX_FIELDS     (MAX_FIELDS),
		.MAX_FIELD_SIZE (MAX_FIELD_SIZE)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.accept_ok (!q_status.full && !clearing),
		.feed      (feed),
		.push      (push),
		.item      (f_item),
		.pos       (f_pos)
	);

	cfd_queue #(
		.WIDTH (QW)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    ({f_item, f_pos}),
		.pop    (pop),
		.dout   ({q_item, q_pos}),
		.status (q_status)
	);

	cfd_back #(
		.MAX_FIELDS     (MAX_FIELDS),
		.MAX_FIELD_SIZE (MAX_FIELD_SIZE)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.q_valid  (q_status.valid),
		.q_item   (q_item),
		.q_pos    (q_pos),
		.pop      (pop),
		.clearing (clearing),
		.result   (result)
	);

endmodule

>>> hdl/cfd_checker.sv
// cfd_checker: port-level assertions on item flow through the block, bound to the top level
// depends on cfd_pkg and crossfade_temporal_dither_top

module cfd_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready
);

	localparam int CAP = cfd_pkg::QUEUE_DEPTH + cfd_pkg::PIPE_SLOTS;
	localparam int OW  = $clog2(CAP + 1);

	logic [OW-1:0] open_q;
	logic          in_xfer;
	logic          out_xfer;

	assign in_xfer  = in_valid && in_ready;
	assign out_xfer = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= '0;
		end else begin
			case ({in_xfer, out_xfer})
				2'b10:   open_q <= open_q + OW'(1);
				2'b01:   open_q <= open_q - OW'(1);
				default: open_q <= open_q;
			endcase
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result valid dropped while stalled");

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> open_q != '0)
		else $error("result without a pending item");

	a_capacity: assert property (@(posedge clk) disable iff (!arst_n)
		open_q <= OW'(CAP))
		else $error("more items in flight than the block holds");

	a_full_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		open_q == OW'(CAP) |-> !in_ready)
		else $error("feed ready while queue and pipeline are full");

endmodule

bind crossfade_temporal_dither_top cfd_checker u_cfd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (feed.valid),
	.in_ready  (feed.ready),
	.out_valid (result.valid),
	.out_ready (result.ready)
);

>>> tb/tb.sv
// tb: self-checking bench for crossfade_temporal_dither_top, with a blend/dither predictor
// in a small scoreboard class, random idling on both channels and register changes between phases
// depends on cfd_pkg, cfd_if and the hdl/ sources of the block

module tb;

	localparam int ITEMS = 1000;
	localparam int SETTLE = 8;
	localparam int HOLD_CYCLES = 40;
	localparam int LIMIT = 300000;
	localparam int STORE_DEPTH = cfd_pkg::MAX_FIELDS_DEF * cfd_pkg::MAX_FIELD_SIZE_DEF;
	localparam logic [cfd_pkg::CFG_IDX_W-1:0] REG_SPARE = 3'd7;

	typedef struct packed {
		logic [cfd_pkg::INDEX_W-1:0] byte_index;
		logic [7:0]                  out_value;
		logic                        frame_done;
	} fade_byte_t;

	class blend_tracker;
		logic [7:0]  residual [STORE_DEPTH];
		int          field_pos;
		int          sub_pos;
		logic [7:0]  gain_code;
		logic [7:0]  black_point;
		logic [7:0]  no_dither_point;
		logic [3:0]  field_size;
		logic [9:0]  field_count;
		logic [23:0] channel_map;
		fade_byte_t  expected_bytes [$];
		int          mismatches;

		function new();
			foreach (residual[i])
				residual[i] = 8'd0;
			field_pos = 0;
			sub_pos = 0;
			gain_code = cfd_pkg::GAIN_RST;
			black_point = cfd_pkg::BLACK_RST;
			no_dither_point = cfd_pkg::NODITH_RST;
			field_size = cfd_pkg::FSIZE_RST;
			field_count = cfd_pkg::FCOUNT_RST;
			channel_map = cfd_pkg::CMAP_RST;
			mismatches = 0;
		endfunction

		function void set_register(logic [cfd_pkg::CFG_IDX_W-1:0] idx,
				logic [cfd_pkg::CFG_DATA_W-1:0] value);
			case (idx)
				cfd_pkg::REG_GAIN: gain_code = value[7:0];
				cfd_pkg::REG_BLACK: black_point = value[7:0];
				cfd_pkg::REG_NO_DITHER: no_dither_point = value[7:0];
				cfd_pkg::REG_FSIZE: field_size = value[3:0];
				cfd_pkg::REG_FCOUNT: field_count = value[9:0];
				cfd_pkg::REG_CMAP: channel_map = value[23:0];
				default: ;
			endcase
		endfunction

		function int pending();
			return expected_bytes.size();
		endfunction

		function void report(string msg);
			mismatches++;
			$display("mismatch at %0t: %s", $realtime, msg);
		endfunction

		function void take_input(logic [7:0] o, logic [7:0] t, logic [7:0] p);
			int size;
			int count;
			int pos;
			int scale;
			int mix24;
			int mix16;
			int mix8;
			int err;
			int level;
			int dest;
			int idx;
			fade_byte_t want;
			size = int'(field_size);
			if (size == 0)
				size = 1;
			if (size > cfd_pkg::MAX_FIELD_SIZE_DEF)
				size = cfd_pkg::MAX_FIELD_SIZE_DEF;
			count = int'(field_count);
			if (count == 0)
				count = 1;
			if (count > cfd_pkg::MAX_FIELDS_DEF)
				count = cfd_pkg::MAX_FIELDS_DEF;
			// counters left past the limits by a register change
			if (sub_pos >= size)
				sub_pos = size - 1;
			if (field_pos >= count)
				field_pos = count - 1;
			pos = field_pos * size + sub_pos;
			scale = int'(gain_code) + 1;
			if (scale <= int'(black_point)) begin
				level = 0;
				residual[pos] = 8'd0;
			end else begin
				mix24 = scale * (int'(o) * (256 - int'(p)) + int'(t) * (int'(p) + 1));
				mix16 = (mix24 >> 8) & 'hFFFF;
				mix8 = (mix16 >> 8) & 'hFF;
				err = int'(residual[pos]) + (mix16 & 'hFF) + (mix24 & 'hFF);
				if (mix8 >= int'(no_dither_point)) begin
					level = mix8 + (err >> 8);
					if (level > 255)
						level = 255;
				end else begin
					level = mix8;
				end
				residual[pos] = err[7:0];
				if (level <= int'(black_point))
					level = 0;
			end
			dest = int'((channel_map >> (3 * sub_pos)) & 24'd7);
			idx = field_pos * size + dest;
			want.byte_index = idx[cfd_pkg::INDEX_W-1:0];
			want.out_value = level[7:0];
			want.frame_done = (sub_pos + 1 >= size) && (field_pos + 1 >= count);
			expected_bytes.push_back(want);
			if (sub_pos + 1 >= size) begin
				sub_pos = 0;
				field_pos = (field_pos + 1 >= count) ? 0 : field_pos + 1;
			end else begin
				sub_pos = sub_pos + 1;
			end
		endfunction

		function void take_result(logic [cfd_pkg::INDEX_W-1:0] idx, logic [7:0] value,
				logic done);
			fade_byte_t want;
			if (expected_bytes.size() == 0) begin
				report($sformatf("unexpected result index %0d value %0d", idx, value));
				return;
			end
			want = expected_bytes.pop_front();
			if (idx !== want.byte_index)
				report($sformatf("byte_index %0d, expected %0d", idx, want.byte_index));
			if (value !== want.out_value)
				report($sformatf("out_value %0d, expected %0d (index %0d)", value, want.out_value,
					want.byte_index));
			if (done !== want.frame_done)
				report($sformatf("frame_done %0b, expected %0b (index %0d)", done, want.frame_done,
					want.byte_index));
		endfunction
	endclass

	logic clk;
	logic arst_n;
	int send_idle = 0;
	int recv_idle = 0;
	bit hold_req = 1'b0;
	int cycles = 0;
	blend_tracker blend = new();

	cfd_in_if feed_if();
	cfd_out_if result_if();
	cfd_cfg_if cfg_if();

	crossfade_temporal_dither_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.feed(feed_if),
		.result(result_if),
		.cfg(cfg_if)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// transfer monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_if.valid && cfg_if.ready)
				blend.set_register(cfg_if.index, cfg_if.data);
			if (feed_if.valid && feed_if.ready)
				blend.take_input(feed_if.origin_value, feed_if.target_value, feed_if.progress_code);
			if (result_if.valid && result_if.ready)
				blend.take_result(result_if.byte_index, result_if.out_value, result_if.frame_done);
		end
	end

	// receiver, with one long hold-off on request
	initial begin
		result_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				result_if.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			result_if.ready <= ($urandom_range(99) >= recv_idle);
		end
	end

	function automatic logic [7:0] pick_byte();
		int r;
		r = $urandom_range(7);
		if (r == 0)
			return 8'd0;
		if (r == 1)
			return 8'd255;
		return 8'($urandom_range(255));
	endfunction

	task automatic send_item(input logic [7:0] o, input logic [7:0] t, input logic [7:0] p);
		while ($urandom_range(99) < send_idle) begin
			feed_if.valid <= 1'b0;
			@(posedge clk);
		end
		feed_if.valid <= 1'b1;
		feed_if.origin_value <= o;
		feed_if.target_value <= t;
		feed_if.progress_code <= p;
		@(posedge clk);
		while (!feed_if.ready)
			@(posedge clk);
	endtask

	task automatic cfg_write(input logic [cfd_pkg::CFG_IDX_W-1:0] idx,
			input logic [cfd_pkg::CFG_DATA_W-1:0] value);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data <= value;
		@(posedge clk);
		while (!cfg_if.ready)
			@(posedge clk);
	endtask

	// unused upper data bits carry noise
	task automatic apply_setting(input logic [7:0] gain, input logic [7:0] black,
			input logic [7:0] no_dither, input logic [3:0] fsize, input logic [9:0] fcount,
			input logic [23:0] cmap);
		logic [23:0] noise;
		noise = 24'($urandom());
		cfg_write(cfd_pkg::REG_GAIN, {noise[23:8], gain});
		cfg_write(cfd_pkg::REG_BLACK, {noise[15:0], black});
		cfg_write(cfd_pkg::REG_NO_DITHER, {noise[19:4], no_dither});
		cfg_write(cfd_pkg::REG_FSIZE, {noise[19:0], fsize});
		cfg_write(cfd_pkg::REG_FCOUNT, {noise[13:0], fcount});
		cfg_write(cfd_pkg::REG_CMAP, cmap);
		cfg_if.valid <= 1'b0;
	endtask

	task automatic random_setting();
		logic [7:0] gain;
		logic [7:0] black;
		logic [3:0] fsize;
		logic [9:0] fcount;
		logic [23:0] cmap;
		int r;
		r = $urandom_range(9);
		gain = (r == 0) ? 8'd0 : (r == 1) ? 8'd255 : 8'($urandom_range(255));
		black = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(30));
		r = $urandom_range(9);
		fsize = (r < 8) ? 4'($urandom_range(1, 8)) : 4'($urandom_range(15));
		r = $urandom_range(9);
		if (r < 6)
			fcount = 10'($urandom_range(1, 24));
		else if (r == 6)
			fcount = 10'd0;
		else if (r == 7)
			fcount = 10'd512;
		else if (r == 8)
			fcount = 10'($urandom_range(513, 1023));
		else
			fcount = 10'($urandom_range(1, 512));
		cmap = ($urandom_range(4) == 0) ? cfd_pkg::CMAP_RST : 24'($urandom());
		apply_setting(gain, black, 8'($urandom_range(255)), fsize, fcount, cmap);
	endtask

	task automatic wait_idle();
		feed_if.valid <= 1'b0;
		@(posedge clk);
		while (blend.pending() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	initial begin
		int sent;
		int n;
		bit held;
		arst_n <= 1'b0;
		feed_if.valid <= 1'b0;
		feed_if.origin_value <= 8'd0;
		feed_if.target_value <= 8'd0;
		feed_if.progress_code <= 8'd0;
		cfg_if.valid <= 1'b0;
		cfg_if.index <= cfd_pkg::REG_GAIN;
		cfg_if.data <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// residual clearing pass
		while (!feed_if.ready)
			@(posedge clk);

		// reset settings: extremes of the bytes and of the progress code
		send_item(8'd0, 8'd0, 8'd0);
		send_item(8'd255, 8'd255, 8'd0);
		send_item(8'd255, 8'd255, 8'd255);
		send_item(8'd255, 8'd0, 8'd0);
		send_item(8'd255, 8'd0, 8'd255);
		send_item(8'd0, 8'd255, 8'd0);
		send_item(8'd0, 8'd255, 8'd255);
		send_item(8'd1, 8'd254, 8'd127);
		send_item(8'd128, 8'd127, 8'd128);
		send_item(8'd170, 8'd85, 8'd1);
		wait_idle();

		// gain blackout, size and count of zero, map beyond the field
		cfg_write(REG_SPARE, 24'($urandom()));
		apply_setting(8'd0, 8'd255, 8'd255, 4'd0, 10'd0, 24'hFFFFFF);
		send_item(8'd255, 8'd255, 8'd255);
		send_item(8'd0, 8'd255, 8'd128);
		send_item(8'd77, 8'd200, 8'd3);
		wait_idle();

		// oversize field and count, black clipping, dither only at full level
		apply_setting(8'd255, 8'd100, 8'd255, 4'd15, 10'd1023, 24'd0);
		send_item(8'd255, 8'd255, 8'd128);
		send_item(8'd255, 8'd254, 8'd200);
		send_item(8'd100, 8'd101, 8'd0);
		send_item(8'd101, 8'd0, 8'd0);
		send_item(8'd0, 8'd99, 8'd255);
		send_item(8'd250, 8'd255, 8'd64);
		wait_idle();

		apply_setting(8'd127, 8'd0, 8'd128, 4'd8, 10'd1, 24'($urandom()));
		send_item(8'd255, 8'd255, 8'd255);
		send_item(8'd200, 8'd10, 8'd30);
		send_item(8'd3, 8'd250, 8'd222);
		send_item(8'd129, 8'd130, 8'd127);
		send_item(8'd64, 8'd192, 8'd100);
		wait_idle();

		sent = 0;
		held = 1'b0;
		while (sent < ITEMS) begin
			if (sent < ITEMS / 3) begin
				send_idle = 9;
				recv_idle = 62;
			end else if (sent < 2 * ITEMS / 3) begin
				send_idle = 62;
				recv_idle = 9;
			end else begin
				send_idle = 0;
				recv_idle = 0;
			end
			random_setting();
			n = $urandom_range(40, 120);
			for (int i = 0; i < n; i++) begin
				if (!held && send_idle == 0 && i == n / 2) begin
					hold_req = 1'b1;
					held = 1'b1;
				end
				send_item(pick_byte(), pick_byte(), pick_byte());
			end
			sent += n;
			wait_idle();
		end

		if (blend.mismatches == 0 && blend.pending() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

>>> crossfade_temporal_dither_top.f
hdl/cfd_pkg.sv
hdl/cfd_if.sv
hdl/cfd_front.sv
hdl/cfd_queue.sv
hdl/cfd_back.sv
hdl/crossfade_temporal_dither_top.sv
hdl/cfd_checker.sv
tb/tb.sv
